[rtl/gse_pkg.sv]
`timescale 1ns / 1ps
// gse_pkg: shared constants, payload types and codes of the grey sobel edge stream
// no dependencies; imported by every module of the block except gse_ram

package gse_pkg;

   // line store geometry
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);

   // image_width register
   localparam int          WIDTH_W     = 11;
   localparam int          CLAMP_W     = (WIDTH_W > COL_W + 1) ? WIDTH_W : COL_W + 1;
   localparam logic [10:0] WIDTH_RESET = 11'd1024;

   // configuration port
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_INDEX_W = CSR_ADDR_W - 2;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH = '0;

   // row phase codes
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_LATER  = 2'd2;

   // divide by three: (sum * RECIP3) >> RECIP3_SHIFT, exact for sums below 2**19
   localparam logic [17:0] RECIP3       = 18'd174763;
   localparam int          RECIP3_SHIFT = 19;

   // command queue between front and back
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       pad_row;
   } req_type;

   typedef struct packed {
      logic [7:0] edge_res;
      logic       last_of_row;
      logic       last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [7:0]       grey;
      logic [COL_W-1:0] col;
      logic             last;
      logic             pad;
      logic [1:0]       phase;
   } cmd_type;

endpackage

[rtl/grey_sobel_edge_stream.sv]
`timescale 1ns / 1ps
// grey_sobel_edge_stream: top level of the streaming grey conversion and sobel edge filter
// depends on gse_pkg, gse_front, gse_cmd_fifo, gse_back (and gse_ram below it)
//
//   channel   ports                          word / handshake
//   req       req_push, req_full, req_data   rgb pixel + pad_row, taken on push & !full
//   rsp       rsp_empty, rsp_pop, rsp_data   edge_res + row/frame marks, taken on pop & !empty
//   csr       csr_psel .. csr_pready         apb write/read, image_width at byte address 0
//
// steps: a colour pixel passes the front through accept, square, divide by three,
//   bit-serial square root and hand-off; a pad pixel goes from accept straight to hand-off
// the back takes each word of work in a fetch step and a read step, with a row-end step on a row end,
//   and waits for its result queue to drain before starting the next pixel
// reset: synchronous, active high; clears row tracking, queues and the left and middle window
//   columns; line stores are not cleared and need no clearing pass
// stalls: a full command queue holds the front, a pending result holds only the back

module grey_sobel_edge_stream import gse_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   // results
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [WIDTH_W-1:0] image_width_ff, image_width_in;
   logic               csr_hit, csr_write;

   cmd_type front_cmd, fifo_head;
   logic    front_push, fifo_full, fifo_empty, back_pop;

   // register decode ignores the byte offset within the word
   assign csr_hit    = csr_paddr[CSR_ADDR_W-1:2] == REG_IMAGE_WIDTH;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(image_width_ff) : '0;

   assign image_width_in = csr_write ? csr_pwdata[WIDTH_W-1:0] : image_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= WIDTH_RESET;
      end else begin
         image_width_ff <= image_width_in;
      end
   end

   // front: handshake, column/phase tracking, colour to grey
   gse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .image_width (image_width_ff),
      .cmd_push    (front_push),
      .cmd_data    (front_cmd),
      .cmd_full    (fifo_full)
   );

   // decoupling queue so either side can stall on its own
   gse_cmd_fifo u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .wdata (front_cmd),
      .full  (fifo_full),
      .pop   (back_pop),
      .rdata (fifo_head),
      .empty (fifo_empty)
   );

   // back: line stores, window, sobel and result queue
   gse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (fifo_head),
      .cmd_empty (fifo_empty),
      .cmd_pop   (back_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/gse_ram.sv]
`timescale 1ns / 1ps
// gse_ram: generic single write port, single read port ram with registered read
// no dependencies

module gse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/gse_cmd_fifo.sv]
`timescale 1ns / 1ps
// gse_cmd_fifo: short command queue between the pixel front and the filter back
// depends on gse_pkg

module gse_cmd_fifo import gse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type wdata,
   output logic    full,
   input  logic    pop,
   output cmd_type rdata,
   output logic    empty
);

   cmd_type              entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_PTR_W:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = count_ff == (CMD_PTR_W + 1)'(CMD_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? CMD_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? CMD_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = (CMD_PTR_W + 1)'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = (CMD_PTR_W + 1)'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[rtl/gse_front.sv]
`timescale 1ns / 1ps
// gse_front: accepts pixels, tracks column and row phase, converts colour to grey
// depends on gse_pkg; feeds gse_cmd_fifo

module gse_front import gse_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  req_type            req_data,
   input  logic [WIDTH_W-1:0] image_width,
   output logic               cmd_push,
   output cmd_type            cmd_data,
   input  logic               cmd_full
);

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_SQ   = 3'd1;
   localparam logic [2:0] F_DIV  = 3'd2;
   localparam logic [2:0] F_SQRT = 3'd3;
   localparam logic [2:0] F_PUSH = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [COL_W-1:0] col_pos_ff, col_pos_in;
   logic [1:0]       phase_ff, phase_in;
   req_type          pix_ff, pix_in;
   cmd_type          cmd_ff, cmd_in;
   logic [17:0]      sum_ff, sum_in;
   logic [15:0]      n_ff, n_in;
   logic [7:0]       root_ff, root_in;
   logic [7:0]       mask_ff, mask_in;

   logic [CLAMP_W-1:0] width_ext, width_clamped;
   logic [COL_W-1:0]   last_col, x_cur;
   logic               is_last, accept;
   logic [15:0]        sq_r, sq_g, sq_b;
   logic [35:0]        prod;
   logic [7:0]         trial;
   logic [15:0]        trial_sq;

   // effective width clamped to one..max width
   always_comb begin
      width_ext = CLAMP_W'(image_width);
      if (width_ext == '0) begin
         width_clamped = CLAMP_W'(1);
      end else if (width_ext > CLAMP_W'(MAX_WIDTH)) begin
         width_clamped = CLAMP_W'(MAX_WIDTH);
      end else begin
         width_clamped = width_ext;
      end
      last_col = COL_W'(width_clamped - CLAMP_W'(1));
      x_cur    = (col_pos_ff > last_col) ? last_col : col_pos_ff;
      is_last  = x_cur == last_col;
   end

   assign req_full = state_ff != F_IDLE;
   assign accept   = req_push && !req_full;

   assign sq_r     = 16'(pix_ff.red) * 16'(pix_ff.red);
   assign sq_g     = 16'(pix_ff.green) * 16'(pix_ff.green);
   assign sq_b     = 16'(pix_ff.blue) * 16'(pix_ff.blue);
   assign prod     = 36'(sum_ff) * 36'(RECIP3);
   assign trial    = root_ff | mask_ff;
   assign trial_sq = 16'(trial) * 16'(trial);

   always_comb begin
      state_in   = state_ff;
      col_pos_in = col_pos_ff;
      phase_in   = phase_ff;
      pix_in     = pix_ff;
      cmd_in     = cmd_ff;
      sum_in     = sum_ff;
      n_in       = n_ff;
      root_in    = root_ff;
      mask_in    = mask_ff;
      cmd_push   = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            // a pad pixel before any image row is dropped outright
            if (accept && !(req_data.pad_row && phase_ff == PHASE_FIRST)) begin
               pix_in       = req_data;
               cmd_in.col   = x_cur;
               cmd_in.last  = is_last;
               cmd_in.pad   = req_data.pad_row;
               cmd_in.phase = phase_ff;
               cmd_in.grey  = '0;
               root_in      = '0;
               mask_in      = 8'h80;
               if (is_last) begin
                  col_pos_in = '0;
                  if (req_data.pad_row) begin
                     phase_in = PHASE_FIRST;
                  end else if (phase_ff != PHASE_LATER) begin
                     phase_in = 2'(phase_ff + 2'd1);
                  end
               end else begin
                  col_pos_in = COL_W'(x_cur + 1'b1);
               end
               state_in = req_data.pad_row ? F_PUSH : F_SQ;
            end
         end
         F_SQ: begin
            sum_in   = 18'(sq_r) + 18'(sq_g) + 18'(sq_b);
            state_in = F_DIV;
         end
         F_DIV: begin
            n_in     = prod[RECIP3_SHIFT +: 16];
            state_in = F_SQRT;
         end
         F_SQRT: begin
            // one result bit per cycle, msb first
            if (trial_sq <= n_ff) begin
               root_in = trial;
            end
            mask_in = mask_ff >> 1;
            if (mask_ff[0]) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            cmd_push = !cmd_full;
            if (!cmd_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_data      = cmd_ff;
      cmd_data.grey = root_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         col_pos_ff <= '0;
         phase_ff   <= PHASE_FIRST;
      end else begin
         state_ff   <= state_in;
         col_pos_ff <= col_pos_in;
         phase_ff   <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff  <= pix_in;
      cmd_ff  <= cmd_in;
      sum_ff  <= sum_in;
      n_ff    <= n_in;
      root_ff <= root_in;
      mask_ff <= mask_in;
   end

   // the grey value handed on is the floor of the square root
   assert property (@(posedge clock) disable iff (reset)
      (cmd_push && !cmd_data.pad) |->
         ((16'(cmd_data.grey) * 16'(cmd_data.grey)) <= n_ff &&
          ((18'(cmd_data.grey) + 18'd1) * (18'(cmd_data.grey) + 18'd1)) > 18'(n_ff)))
      else $error("grey value is not the floor square root");

   // a pad pixel ahead of the first row leaves row tracking alone
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.pad_row && phase_ff == PHASE_FIRST) |=>
         (col_pos_ff == $past(col_pos_ff) && phase_ff == PHASE_FIRST && !req_full))
      else $error("pad pixel in first phase changed row state");

endmodule

[rtl/gse_back.sv]
`timescale 1ns / 1ps
// gse_back: line stores, 3x3 window and sobel magnitude, with a two word result queue
// depends on gse_pkg and gse_ram; fed by gse_cmd_fifo

module gse_back import gse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd_head,
   input  logic    cmd_empty,
   output logic    cmd_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_READ = 2'd1;
   localparam logic [1:0] B_LAST = 2'd2;

   // one window column: top, middle, bottom
   typedef logic [2:0][7:0] column_type;

   function automatic logic [7:0] sobel_mag(input column_type l, input column_type m,
                                            input column_type r);
      logic [9:0]         rs, ls, ts, bs;
      logic signed [11:0] gx, gy;
      logic [11:0]        ax, ay, s;
      rs = {2'b0, r[0]} + {1'b0, r[1], 1'b0} + {2'b0, r[2]};
      ls = {2'b0, l[0]} + {1'b0, l[1], 1'b0} + {2'b0, l[2]};
      bs = {2'b0, l[2]} + {1'b0, m[2], 1'b0} + {2'b0, r[2]};
      ts = {2'b0, l[0]} + {1'b0, m[0], 1'b0} + {2'b0, r[0]};
      gx = $signed({2'b0, rs}) - $signed({2'b0, ls});
      gy = $signed({2'b0, bs}) - $signed({2'b0, ts});
      ax = gx[11] ? 12'($unsigned(-gx)) : 12'($unsigned(gx));
      ay = gy[11] ? 12'($unsigned(-gy)) : 12'($unsigned(gy));
      s  = ax + ay;
      return (s > 12'd255) ? 8'hFF : s[7:0];
   endfunction

   logic [1:0] state_ff, state_in;
   cmd_type    cmd_ff, cmd_in;
   column_type left_ff, left_in;
   column_type mid_ff, mid_in;
   column_type right_ff, right_in;
   column_type right_col;

   logic       ram_rd_en, ram_wr_en;
   logic [7:0] upper_rd, middle_rd;

   rsp_type    oq_ff [2];
   logic       oq_head_ff, oq_head_in;
   logic [1:0] oq_count_ff, oq_count_in;
   logic       oq_push, oq_pop;
   rsp_type    oq_wdata;
   logic       oq_slot;

   gse_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_upper (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cmd_ff.col),
      .wr_data (middle_rd),
      .rd_en   (ram_rd_en),
      .rd_addr (cmd_head.col),
      .rd_data (upper_rd)
   );

   gse_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_middle (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cmd_ff.col),
      .wr_data (cmd_ff.grey),
      .rd_en   (ram_rd_en),
      .rd_addr (cmd_head.col),
      .rd_data (middle_rd)
   );

   // new right column with top and bottom clamping
   always_comb begin
      right_col[1] = middle_rd;
      right_col[0] = (cmd_ff.phase == PHASE_LATER) ? upper_rd : middle_rd;
      right_col[2] = cmd_ff.pad ? middle_rd : cmd_ff.grey;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      left_in   = left_ff;
      mid_in    = mid_ff;
      right_in  = right_ff;
      cmd_pop   = 1'b0;
      ram_rd_en = 1'b0;
      ram_wr_en = 1'b0;
      oq_push   = 1'b0;
      oq_wdata  = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (!cmd_empty && oq_count_ff == 2'd0) begin
               cmd_pop   = 1'b1;
               ram_rd_en = 1'b1;
               cmd_in    = cmd_head;
               state_in  = B_READ;
            end
         end
         B_READ: begin
            ram_wr_en = !cmd_ff.pad;
            right_in  = right_col;
            state_in  = B_IDLE;
            if (cmd_ff.phase != PHASE_FIRST) begin
               if (cmd_ff.col == '0) begin
                  left_in = right_col;
                  mid_in  = right_col;
               end else begin
                  oq_push           = 1'b1;
                  oq_wdata.edge_res = sobel_mag(left_ff, mid_ff, right_col);
                  left_in           = mid_ff;
                  mid_in            = right_col;
               end
               if (cmd_ff.last) begin
                  state_in = B_LAST;
               end
            end
         end
         B_LAST: begin
            // right edge clamps onto itself
            oq_push                = 1'b1;
            oq_wdata.edge_res      = sobel_mag(left_ff, mid_ff, right_ff);
            oq_wdata.last_of_row   = 1'b1;
            oq_wdata.last_of_frame = cmd_ff.pad;
            state_in               = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // result queue
   assign rsp_empty = oq_count_ff == 2'd0;
   assign rsp_data  = oq_ff[oq_head_ff];
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign oq_slot   = oq_head_ff ^ oq_count_ff[0];

   always_comb begin
      oq_head_in  = oq_pop ? !oq_head_ff : oq_head_ff;
      oq_count_in = oq_count_ff;
      if (oq_push && !oq_pop) begin
         oq_count_in = 2'(oq_count_ff + 2'd1);
      end else if (oq_pop && !oq_push) begin
         oq_count_in = 2'(oq_count_ff - 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_IDLE;
         oq_head_ff  <= 1'b0;
         oq_count_ff <= 2'd0;
         left_ff     <= '0;
         mid_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         oq_head_ff  <= oq_head_in;
         oq_count_ff <= oq_count_in;
         left_ff     <= left_in;
         mid_ff      <= mid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      right_ff <= right_in;
      if (oq_push) begin
         oq_ff[oq_slot] <= oq_wdata;
      end
   end

   // a command starts only with room for both of its words
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (oq_count_ff == 2'd0 && state_ff == B_IDLE))
      else $error("command taken while results still queued");

   // the two word queue never overflows
   assert property (@(posedge clock) disable iff (reset)
      oq_push |-> (oq_count_ff != 2'd2))
      else $error("result queue overflow");

   // end of frame only ever marks a row end
   assert property (@(posedge clock) disable iff (reset)
      (oq_push && oq_wdata.last_of_frame) |-> (oq_wdata.last_of_row && cmd_ff.last))
      else $error("frame end on a word that is not a row end");

endmodule
